>>> hdl/jlpf_pkg.sv
// ----------------------------------------------------------------------------
// jlpf_pkg
// Shared types, constants and helpers for the joint limit potential field
// PD core: register indexes, reset values, stage numbers, pipeline record.
// ----------------------------------------------------------------------------
`default_nettype none

package jlpf_pkg;

  // register indexes on the configuration port
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INFLUENCE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ATTRACT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPEL       = 3'd4;

  // register reset values, Q16.16
  localparam logic signed [31:0] UPPER_RST     = 32'sd102944;
  localparam logic signed [31:0] LOWER_RST     = -32'sd102944;
  localparam logic [30:0]        INFLUENCE_RST = 31'd5719;
  localparam logic [30:0]        ATTRACT_RST   = 31'd65536;
  localparam logic [30:0]        REPEL_RST     = 31'd65536;

  localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;

  // width of the wide signed sums fed to the clamp
  localparam int unsigned SAT_W = 50;

  // quotient bits of the repulsion divider, one stage each
  localparam int unsigned QW = 31;

  // stage numbers
  localparam int unsigned ST_DIFF     = 0;
  localparam int unsigned ST_ABS      = 1;
  localparam int unsigned ST_SQR      = 2;
  localparam int unsigned ST_CUBE     = 3;
  localparam int unsigned ST_CUBE_SUM = 4;
  localparam int unsigned ST_DEN      = 5;
  localparam int unsigned ST_DEN_SUM  = 6;
  localparam int unsigned ST_DIV_INIT = 7;
  localparam int unsigned ST_DIV0     = 8;
  localparam int unsigned ST_REPEL    = ST_DIV0 + QW;
  localparam int unsigned ST_VERR     = ST_REPEL + 1;
  localparam int unsigned ST_KD       = ST_VERR + 1;
  localparam int unsigned ST_TORQUE   = ST_KD + 1;
  localparam int unsigned NUM_ST      = ST_TORQUE + 1;

  // record that travels down the pipeline
  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic signed [31:0] grav;
    logic signed [31:0] cor;
    logic [30:0]        kp;
    logic [30:0]        kd;
    logic signed [31:0] err;
    logic               flag;
    logic signed [32:0] dup;
    logic signed [32:0] dlp;
    logic               lower;
    logic [32:0]        dnear;
    logic               active;
    logic               dzero;
    logic signed [46:0] att;
    logic signed [46:0] kpe;
    logic [61:0]        d2;
    logic [61:0]        nq;
    logic [61:0]        plo;
    logic [61:0]        phi;
    logic [92:0]        d3;
    logic [61:0]        q0;
    logic [61:0]        q1;
    logic [61:0]        q2;
    logic [123:0]       den;
    logic [109:0]       rem;
    logic [QW-1:0]      quot;
    logic               msat;
    logic signed [31:0] vdes;
    logic signed [31:0] verr;
    logic signed [46:0] kdw;
    logic signed [31:0] tau;
  } pipe_t;

  // clamp to 32 bit signed, returns {clamped, value}
  function automatic logic [32:0] sat32(input logic signed [SAT_W-1:0] x);
    logic [32:0] r;
    if (x[SAT_W-1:31] == '0 || x[SAT_W-1:31] == '1) begin
      r = {1'b0, x[31:0]};
    end else if (x[SAT_W-1]) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b1, 32'h7FFF_FFFF};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/joint_limit_potential_field_pd_core.sv
// ----------------------------------------------------------------------------
// joint_limit_potential_field_pd_core
// Per-joint PD torque with an attractive velocity toward the target and a
// repulsive velocity away from the nearer joint limit, all Q16.16.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                  payload
//  in       sink       in_valid_i / in_ready_o    position .. deriv_gain
//  out      source     out_valid_o / out_ready_i  torque_command .. saturated
//  cfg      sink       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
//  one joint enters per cycle while the output is not stalled; 43 register
//  stages, most of them the 31-stage restoring divider of the repulsion
//  term, with the multiply stages around it
//  each stage holds its item until the next one frees, so bubbles collapse
//  and a stall loses or repeats nothing; cfg writes are always accepted
//  reset clears the valid bits and loads the register defaults
`default_nettype none

module joint_limit_potential_field_pd_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output      logic                             in_ready_o,
  input  wire logic signed [31:0]               position_i,
  input  wire logic signed [31:0]               velocity_i,
  input  wire logic signed [31:0]               target_position_i,
  input  wire logic signed [31:0]               gravity_torque_i,
  input  wire logic signed [31:0]               coriolis_torque_i,
  input  wire logic [30:0]                      prop_gain_i,
  input  wire logic [30:0]                      deriv_gain_i,
  output      logic                             out_valid_o,
  input  wire logic                             out_ready_i,
  output      logic signed [31:0]               torque_command_o,
  output      logic signed [31:0]               desired_velocity_o,
  output      logic signed [31:0]               position_error_o,
  output      logic                             repulsion_active_o,
  output      logic                             saturated_o,
  input  wire logic                             cfg_valid_i,
  output      logic                             cfg_ready_o,
  input  wire logic [jlpf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [31:0]                      cfg_data_i
);

  localparam int unsigned LAST = jlpf_pkg::NUM_ST - 1;

  logic signed [31:0] upper_q, lower_q;
  logic [30:0]        infl_q, katt_q, krep_q;

  jlpf_pkg::pipe_t              st_d [jlpf_pkg::NUM_ST];
  jlpf_pkg::pipe_t              st_q [jlpf_pkg::NUM_ST];
  logic [jlpf_pkg::NUM_ST-1:0]  v_q;
  logic [jlpf_pkg::NUM_ST-1:0]  en;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= jlpf_pkg::UPPER_RST;
      lower_q <= jlpf_pkg::LOWER_RST;
      infl_q  <= jlpf_pkg::INFLUENCE_RST;
      katt_q  <= jlpf_pkg::ATTRACT_RST;
      krep_q  <= jlpf_pkg::REPEL_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        jlpf_pkg::REG_UPPER_LIMIT: upper_q <= cfg_data_i;
        jlpf_pkg::REG_LOWER_LIMIT: lower_q <= cfg_data_i;
        jlpf_pkg::REG_INFLUENCE:   infl_q  <= cfg_data_i[30:0];
        jlpf_pkg::REG_ATTRACT:     katt_q  <= cfg_data_i[30:0];
        jlpf_pkg::REG_REPEL:       krep_q  <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // stage enables: a stage loads when empty or when its successor loads
  assign en[LAST] = !v_q[LAST] || out_ready_i;
  for (genvar g = 0; g < LAST; g++) begin : g_en
    assign en[g] = !v_q[g] || en[g+1];
  end
  assign in_ready_o = en[0];

  // stage 0: position error and signed distances to the limits
  always_comb begin
    logic [32:0] s;
    st_d[0]      = '0;
    st_d[0].pos  = position_i;
    st_d[0].vel  = velocity_i;
    st_d[0].grav = gravity_torque_i;
    st_d[0].cor  = coriolis_torque_i;
    st_d[0].kp   = prop_gain_i;
    st_d[0].kd   = deriv_gain_i;
    s = jlpf_pkg::sat32(jlpf_pkg::SAT_W'(target_position_i)
                        - jlpf_pkg::SAT_W'(position_i));
    st_d[0].err  = s[31:0];
    st_d[0].flag = s[32];
    st_d[0].dup  = 33'(upper_q) - 33'(position_i);
    st_d[0].dlp  = 33'(lower_q) - 33'(position_i);
  end

  for (genvar g = 1; g < jlpf_pkg::NUM_ST; g++) begin : g_stage
    if (g == jlpf_pkg::ST_ABS) begin : g_abs
      // nearer limit, activity, attractive and proportional products
      always_comb begin
        logic [32:0] du, dl;
        logic signed [63:0] pa, pp;
        st_d[g] = st_q[g-1];
        du = st_q[g-1].dup[32] ? 33'(-st_q[g-1].dup) : st_q[g-1].dup;
        dl = st_q[g-1].dlp[32] ? 33'(-st_q[g-1].dlp) : st_q[g-1].dlp;
        st_d[g].lower  = !(du < dl);
        st_d[g].dnear  = st_d[g].lower ? dl : du;
        st_d[g].active = st_d[g].dnear <= {2'b0, infl_q};
        st_d[g].dzero  = st_d[g].dnear == '0;
        pa = $signed({1'b0, katt_q}) * st_q[g-1].err;
        pp = $signed({1'b0, st_q[g-1].kp}) * st_q[g-1].err;
        st_d[g].att = pa[62:16];
        st_d[g].kpe = pp[62:16];
      end
    end else if (g == jlpf_pkg::ST_SQR) begin : g_sqr
      // distance squared and repulsion numerator
      always_comb begin
        st_d[g] = st_q[g-1];
        st_d[g].d2 = {31'b0, st_q[g-1].dnear[30:0]} * {31'b0, st_q[g-1].dnear[30:0]};
        st_d[g].nq = {31'b0, krep_q} * {31'b0, 31'(infl_q - st_q[g-1].dnear[30:0])};
      end
    end else if (g == jlpf_pkg::ST_CUBE) begin : g_cube
      // partial products of the cube
      always_comb begin
        st_d[g] = st_q[g-1];
        st_d[g].plo = {31'b0, st_q[g-1].d2[30:0]} * {31'b0, st_q[g-1].dnear[30:0]};
        st_d[g].phi = {31'b0, st_q[g-1].d2[61:31]} * {31'b0, st_q[g-1].dnear[30:0]};
      end
    end else if (g == jlpf_pkg::ST_CUBE_SUM) begin : g_cube_sum
      always_comb begin
        st_d[g] = st_q[g-1];
        st_d[g].d3 = {31'b0, st_q[g-1].plo} + {st_q[g-1].phi, 31'b0};
      end
    end else if (g == jlpf_pkg::ST_DEN) begin : g_den
      // partial products of the divisor, cube times influence distance
      always_comb begin
        st_d[g] = st_q[g-1];
        st_d[g].q0 = {31'b0, st_q[g-1].d3[30:0]} * {31'b0, infl_q};
        st_d[g].q1 = {31'b0, st_q[g-1].d3[61:31]} * {31'b0, infl_q};
        st_d[g].q2 = {31'b0, st_q[g-1].d3[92:62]} * {31'b0, infl_q};
      end
    end else if (g == jlpf_pkg::ST_DEN_SUM) begin : g_den_sum
      always_comb begin
        st_d[g] = st_q[g-1];
        st_d[g].den = {62'b0, st_q[g-1].q0} + {31'b0, st_q[g-1].q1, 31'b0}
                    + {st_q[g-1].q2, 62'b0};
      end
    end else if (g == jlpf_pkg::ST_DIV_INIT) begin : g_div_init
      // quotient overflow check and dividend load
      always_comb begin
        st_d[g] = st_q[g-1];
        st_d[g].msat = {45'b0, st_q[g-1].nq, 17'b0} >= st_q[g-1].den;
        st_d[g].rem  = {st_q[g-1].nq, 48'b0};
        st_d[g].quot = '0;
      end
    end else if (g >= jlpf_pkg::ST_DIV0 && g < jlpf_pkg::ST_REPEL) begin : g_div
      localparam int unsigned K = jlpf_pkg::QW - 1 - (g - jlpf_pkg::ST_DIV0);
      // one restoring step per stage, quotient bit K
      always_comb begin
        logic [154:0] sh;
        st_d[g] = st_q[g-1];
        sh = {31'b0, st_q[g-1].den} << K;
        if ({45'b0, st_q[g-1].rem} >= sh) begin
          st_d[g].rem     = st_q[g-1].rem - sh[109:0];
          st_d[g].quot[K] = 1'b1;
        end
      end
    end else if (g == jlpf_pkg::ST_REPEL) begin : g_repel
      // repulsion magnitude and desired velocity
      always_comb begin
        logic [30:0] mag;
        logic signed [jlpf_pkg::SAT_W-1:0] rep;
        logic [32:0] s;
        logic f;
        st_d[g] = st_q[g-1];
        f = 1'b0;
        if (!st_q[g-1].active) begin
          mag = '0;
        end else if (st_q[g-1].dzero || st_q[g-1].msat) begin
          mag = jlpf_pkg::MAX31;
          f   = 1'b1;
        end else begin
          mag = st_q[g-1].quot;
        end
        rep = $signed({19'b0, mag});
        if (!st_q[g-1].lower) begin
          rep = -rep;
        end
        s = jlpf_pkg::sat32(jlpf_pkg::SAT_W'(st_q[g-1].att) + rep);
        st_d[g].vdes = s[31:0];
        st_d[g].flag = st_q[g-1].flag | f | s[32];
      end
    end else if (g == jlpf_pkg::ST_VERR) begin : g_verr
      always_comb begin
        logic [32:0] s;
        st_d[g] = st_q[g-1];
        s = jlpf_pkg::sat32(jlpf_pkg::SAT_W'(st_q[g-1].vdes)
                            - jlpf_pkg::SAT_W'(st_q[g-1].vel));
        st_d[g].verr = s[31:0];
        st_d[g].flag = st_q[g-1].flag | s[32];
      end
    end else if (g == jlpf_pkg::ST_KD) begin : g_kd
      always_comb begin
        logic signed [63:0] pd;
        st_d[g] = st_q[g-1];
        pd = $signed({1'b0, st_q[g-1].kd}) * st_q[g-1].verr;
        st_d[g].kdw = pd[62:16];
      end
    end else begin : g_torque
      // torque sum and final clamp
      always_comb begin
        logic [32:0] s;
        st_d[g] = st_q[g-1];
        s = jlpf_pkg::sat32(jlpf_pkg::SAT_W'(st_q[g-1].grav)
                            + jlpf_pkg::SAT_W'(st_q[g-1].cor)
                            + jlpf_pkg::SAT_W'(st_q[g-1].kpe)
                            + jlpf_pkg::SAT_W'(st_q[g-1].kdw));
        st_d[g].tau  = s[31:0];
        st_d[g].flag = st_q[g-1].flag | s[32];
      end
    end
  end

  // stage registers
  for (genvar g = 0; g < jlpf_pkg::NUM_ST; g++) begin : g_reg
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en[g]) begin
        v_q[g] <= (g == 0) ? in_valid_i : v_q[(g == 0) ? 0 : g-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[g]) begin
        st_q[g] <= st_d[g];
      end
    end
  end

  // result ports
  assign out_valid_o        = v_q[LAST];
  assign torque_command_o   = st_q[LAST].tau;
  assign desired_velocity_o = st_q[LAST].vdes;
  assign position_error_o   = st_q[LAST].err;
  assign repulsion_active_o = st_q[LAST].active;
  assign saturated_o        = st_q[LAST].flag;

  // checks
  a_dzero_flags : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && st_q[LAST].dzero |-> saturated_o && repulsion_active_o)
    else $error("zero distance result without active and saturated");

  a_in_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v_q[0])
    else $error("accepted item missing from first stage");

  a_empty_out_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with output stage empty");

endmodule

`default_nettype wire
